// ----- hdl/clfe_pkg.sv -----
// Package for the CAN/LIN frame encoder: record byte constants, register
// map and the control struct between sequencer and checksum unit.
// No dependencies.
`default_nettype none

package clfe_pkg;

    // Record bytes
    localparam logic [7:0] PROTO_CAN_A = 8'h50;
    localparam logic [7:0] PROTO_CAN_B = 8'h58;
    localparam logic [7:0] PROTO_LIN   = 8'hB8;
    localparam logic [7:0] ESC_BYTE    = 8'hFF;
    localparam logic [7:0] DONE_CODE   = 8'h10;
    localparam logic [7:0] END_LOW     = 8'h00;
    localparam logic [7:0] EXT_FLAG    = 8'h80;

    // Header holds up to five bytes, byte 0 in the low bits
    localparam int unsigned HDR_BYTES = 5;
    localparam logic [2:0]  HDR_CNT_EXT = 3'd5;
    localparam logic [2:0]  HDR_CNT_STD = 3'd3;
    localparam logic [2:0]  HDR_CNT_LIN = 3'd2;

    // Register map
    localparam int unsigned ADDR_W      = 3;
    localparam logic [ADDR_W-1:0] REG_CC_ADDR = 3'd0;

    // Control request to the checksum fold unit
    typedef struct packed {
        logic       clear;
        logic       add;
        logic [7:0] data;
    } t_fold_ctl;

endpackage

`default_nettype wire

// ----- hdl/clfe_fold.sv -----
// Checksum fold unit: end-around-carry byte accumulator shared by every
// data and escape byte of a record. Depends on clfe_pkg.
`default_nettype none

module clfe_fold (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  clfe_pkg::t_fold_ctl  i_ctl,
    output logic [7:0]           o_sum
);

    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic [8:0] w_raw;

    // Add the byte, then fold the carry back in; sum of two bytes cannot carry twice
    always_comb begin
        w_raw = {1'b0, r_sum} + {1'b0, i_ctl.data};
        n_sum = r_sum;
        if (i_ctl.clear) begin
            n_sum = 8'h00;
        end else if (i_ctl.add) begin
            n_sum = w_raw[7:0] + {7'd0, w_raw[8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 8'h00;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ----- hdl/clfe_seq.sv -----
// Record sequencer: walks header, data (with 0xFF doubling), checksum (LIN only),
// complete code (when enabled) and end marker, one byte per cycle. Depends on clfe_pkg.
`default_nettype none

module clfe_seq #(
    parameter int unsigned MAX_PAYLOAD = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire  [1:0]           i_bus_select,
    input  wire                  i_is_extended,
    input  wire  [28:0]          i_frame_id,
    input  wire  [3:0]           i_byte_count,
    input  wire  [63:0]          i_payload,
    input  wire                  i_append_cc,
    input  wire  [7:0]           i_sum,
    output clfe_pkg::t_fold_ctl  o_fold,
    output logic                 o_busy,
    output logic                 o_strobe,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_byte
);

    localparam int unsigned PW = 8 * MAX_PAYLOAD;
    localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_DATA,
        ST_ESC,
        ST_CSUM,
        ST_CODE,
        ST_ENDF,
        ST_END0
    } t_state;

    t_state                          r_state, n_state;
    logic [8*clfe_pkg::HDR_BYTES-1:0] r_hdr, n_hdr;
    logic [2:0]                      r_hdr_cnt, n_hdr_cnt;
    logic [PW-1:0]                   r_payload, n_payload;
    logic [LW-1:0]                   r_left, n_left;
    logic                            r_lin, n_lin;
    logic                            r_strobe, n_strobe;
    logic [7:0]                      r_byte, n_byte;
    logic                            r_last, n_last;
    t_state                          w_after;
    logic [7:0]                      w_proto;

    // State that follows the last data byte
    always_comb begin
        if (r_lin) begin
            w_after = ST_CSUM;
        end else if (i_append_cc) begin
            w_after = ST_CODE;
        end else begin
            w_after = ST_ENDF;
        end
    end

    assign w_proto = i_bus_select[0] ? clfe_pkg::PROTO_CAN_B : clfe_pkg::PROTO_CAN_A;

    // Next-state and output byte selection
    always_comb begin
        n_state   = r_state;
        n_hdr     = r_hdr;
        n_hdr_cnt = r_hdr_cnt;
        n_payload = r_payload;
        n_left    = r_left;
        n_lin     = r_lin;
        n_strobe  = 1'b0;
        n_byte    = r_byte;
        n_last    = 1'b0;
        o_fold    = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_lin      = i_bus_select[1];
                    n_payload  = i_payload[PW-1:0];
                    o_fold.clear = 1'b1;
                    if (i_byte_count > 4'(MAX_PAYLOAD)) begin
                        n_left = LW'(MAX_PAYLOAD);
                    end else begin
                        n_left = LW'(i_byte_count);
                    end
                    if (i_bus_select[1]) begin
                        n_hdr     = {24'd0, i_frame_id[7:0], clfe_pkg::PROTO_LIN};
                        n_hdr_cnt = clfe_pkg::HDR_CNT_LIN;
                    end else if (i_is_extended) begin
                        n_hdr     = {i_frame_id[7:0], i_frame_id[15:8], i_frame_id[23:16],
                                     clfe_pkg::EXT_FLAG | {3'd0, i_frame_id[28:24]},
                                     w_proto};
                        n_hdr_cnt = clfe_pkg::HDR_CNT_EXT;
                    end else begin
                        n_hdr     = {16'd0, i_frame_id[7:0], {5'd0, i_frame_id[10:8]},
                                     w_proto};
                        n_hdr_cnt = clfe_pkg::HDR_CNT_STD;
                    end
                    n_state = ST_HDR;
                end
            end
            ST_HDR: begin
                n_strobe  = 1'b1;
                n_byte    = r_hdr[7:0];
                n_hdr     = r_hdr >> 8;
                n_hdr_cnt = r_hdr_cnt - 3'd1;
                if (r_hdr_cnt == 3'd1) begin
                    n_state = (r_left != '0) ? ST_DATA : w_after;
                end
            end
            ST_DATA: begin
                n_strobe    = 1'b1;
                n_byte      = r_payload[7:0];
                o_fold.add  = 1'b1;
                o_fold.data = r_payload[7:0];
                n_payload   = r_payload >> 8;
                n_left      = r_left - LW'(1);
                if (r_payload[7:0] == clfe_pkg::ESC_BYTE) begin
                    n_state = ST_ESC;
                end else if (r_left == LW'(1)) begin
                    n_state = w_after;
                end
            end
            ST_ESC: begin
                n_strobe    = 1'b1;
                n_byte      = clfe_pkg::ESC_BYTE;
                o_fold.add  = 1'b1;
                o_fold.data = clfe_pkg::ESC_BYTE;
                n_state     = (r_left == '0) ? w_after : ST_DATA;
            end
            ST_CSUM: begin
                n_strobe = 1'b1;
                n_byte   = ~i_sum;
                n_state  = i_append_cc ? ST_CODE : ST_ENDF;
            end
            ST_CODE: begin
                n_strobe = 1'b1;
                n_byte   = clfe_pkg::DONE_CODE;
                n_state  = ST_ENDF;
            end
            ST_ENDF: begin
                n_strobe = 1'b1;
                n_byte   = clfe_pkg::ESC_BYTE;
                n_state  = ST_END0;
            end
            ST_END0: begin
                n_strobe = 1'b1;
                n_byte   = clfe_pkg::END_LOW;
                n_last   = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
        r_hdr     <= n_hdr;
        r_hdr_cnt <= n_hdr_cnt;
        r_payload <= n_payload;
        r_left    <= n_left;
        r_lin     <= n_lin;
        r_byte    <= n_byte;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;

endmodule

`default_nettype wire

// ----- hdl/can_lin_frame_encoder_top.sv -----
// CAN/LIN frame encoder: one record byte per cycle from the sequencer FSM.
//   An accepted request enters ST_HDR; the first byte then shows with o_strobe.
//   Records run 5 to 24 bytes (header, doubled 0xFF data, checksum, code, FF 00).
//   Busy drops while the final 0x00 is shown, so a new request can be accepted
//   as the record ends. Synchronous active-low reset clears the sequencer state,
//   the checksum and the register; results cannot be stalled.
`default_nettype none

module can_lin_frame_encoder_top #(
    parameter int unsigned MAX_PAYLOAD = 8
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // APB configuration
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [clfe_pkg::ADDR_W-1:0]   paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Frame request
    input  wire                           start,
    output logic                          busy,
    input  wire  [1:0]                    i_bus_select,
    input  wire                           i_is_extended,
    input  wire  [28:0]                   i_frame_id,
    input  wire  [3:0]                    i_byte_count,
    input  wire  [63:0]                   i_payload,
    // Record bytes
    output logic                          o_strobe,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last_byte
);

    logic                r_append_cc;
    logic                w_busy;
    logic [7:0]          w_sum;
    clfe_pkg::t_fold_ctl w_fold;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_append_cc <= 1'b0;
        end else if (psel && penable && pwrite && (paddr == clfe_pkg::REG_CC_ADDR)) begin
            r_append_cc <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == clfe_pkg::REG_CC_ADDR) ? {31'd0, r_append_cc} : 32'd0;

    clfe_seq #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_bus_select  (i_bus_select),
        .i_is_extended (i_is_extended),
        .i_frame_id    (i_frame_id),
        .i_byte_count  (i_byte_count),
        .i_payload     (i_payload),
        .i_append_cc   (r_append_cc),
        .i_sum         (w_sum),
        .o_fold        (w_fold),
        .o_busy        (w_busy),
        .o_strobe      (o_strobe),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte)
    );

    clfe_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fold),
        .o_sum   (w_sum)
    );

    assign busy = w_busy;

endmodule

`default_nettype wire

// ----- hdl/clfe_chk.sv -----
// Port-level checks for the CAN/LIN frame encoder, bound to the top level.
// Depends on can_lin_frame_encoder_top.
`default_nettype none

module clfe_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_strobe,
    input wire [7:0]  o_out_byte,
    input wire        o_last_byte
);

    // Record ends on 0x00 and only with a strobe
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_byte |-> (o_strobe && (o_out_byte == 8'h00)))
        else $error("last byte without strobe or not zero");

    // End marker: 0xFF precedes the final byte
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_last_byte && $past(i_rst_n)) |-> ($past(o_strobe) && ($past(o_out_byte) == 8'hFF)))
        else $error("end marker not preceded by 0xFF");

    // Accepted request is followed by a strobed first byte that is not the last byte
    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 (o_strobe && !o_last_byte))
        else $error("no first byte after accepted request");

    // Bytes of one record are contiguous
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_byte) |=> o_strobe)
        else $error("gap inside record");

endmodule

bind can_lin_frame_encoder_top clfe_chk u_clfe_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_out_byte  (o_out_byte),
    .o_last_byte (o_last_byte)
);

`default_nettype wire
